>>> rtl/core/assert_macros.svh
// Assertion helpers; both expand to nothing in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> rtl/core/stbs_pkg.sv
`timescale 1ns / 1ps

package stbs_pkg;

  localparam int unsigned IdxW  = 10;  // position fields
  localparam int unsigned CntW  = 11;  // entry count and match count
  localparam int unsigned DataW = 32;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e                  opcode;
    logic [IdxW-1:0]          entry_index;
    logic signed [DataW-1:0]  item_value;
  } item_t;

  typedef struct packed {
    logic [IdxW-1:0] lower_index;
    logic            lower_valid;
    logic [IdxW-1:0] upper_index;
    logic            upper_valid;
    logic [IdxW-1:0] first_match_res;
    logic [IdxW-1:0] last_match;
    logic            found;
    logic [CntW-1:0] match_count;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_en;     // store the entry of a write transfer
    logic start;     // latch key, open both search windows
    logic update;    // registered read data valid: narrow windows
    logic load_out;  // move finished result into output register
  } stbs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic active;    // at least one search window still non-empty
  } stbs_status_t;

endpackage

>>> rtl/core/stbs_ctrl.sv
`timescale 1ns / 1ps

module stbs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  stbs_pkg::opcode_e     opcode_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  stbs_pkg::stbs_status_t status_i,
  output stbs_pkg::stbs_cmd_t   cmd_o
);
  import stbs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == OP_QUERY) begin
            cmd_o.start = 1'b1;
            state_d     = ST_READ;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      ST_READ: begin
        state_d = status_i.active ? ST_CMP : ST_FIN;
      end
      ST_CMP: begin
        cmd_o.update = 1'b1;
        state_d      = ST_READ;
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/stbs_dpath.sv
`timescale 1ns / 1ps

module stbs_dpath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [stbs_pkg::CntW-1:0] cfg_wdata_i,
  input  stbs_pkg::item_t          item_i,
  input  stbs_pkg::stbs_cmd_t      cmd_i,
  output stbs_pkg::stbs_status_t   status_o,
  output stbs_pkg::result_t        result_o
);
  import stbs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);      // table address
  localparam int NW = $clog2(TABLE_DEPTH + 1);  // window bounds, 0..depth

  logic [CntW-1:0]         entries_q;
  logic signed [DataW-1:0] key_q;

  // Window per path: [lo, hx) where hx is one past the last candidate.
  // Path A drives >= and first-equal, path B drives > and last-equal.
  logic [NW-1:0] lo_a_q, hx_a_q, lo_b_q, hx_b_q;
  logic [NW-1:0] n_eff;
  logic [NW:0]   sum_a, sum_b;
  logic [AW-1:0] m_a, m_b;
  logic          act_a, act_b;

  logic signed [DataW-1:0] table_mem [TABLE_DEPTH];
  logic signed [DataW-1:0] rd_a_q, rd_b_q;
  logic                    wr_hit;
  logic [AW-1:0]           wr_addr;

  logic          lb_v_q, ub_v_q, fp_v_q, lp_v_q;
  logic [AW-1:0] lb_q, ub_q, fp_q, lp_q;
  logic          ge_a, eq_a, gt_b, eq_b;

  logic [AW:0]   span;
  logic          found;
  result_t       res_d, res_q;

  // entries_in_use saturates at the table depth
  assign n_eff = (int'(entries_q) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(entries_q);

  assign act_a = lo_a_q < hx_a_q;
  assign act_b = lo_b_q < hx_b_q;
  assign status_o.active = act_a || act_b;

  // floor((lo + hi) / 2) with hi = hx - 1
  assign sum_a = {1'b0, lo_a_q} + {1'b0, hx_a_q} - (NW+1)'(1);
  assign sum_b = {1'b0, lo_b_q} + {1'b0, hx_b_q} - (NW+1)'(1);
  assign m_a   = sum_a[AW:1];
  assign m_b   = sum_b[AW:1];

  assign wr_hit  = cmd_i.wr_en && (int'(item_i.entry_index) < TABLE_DEPTH);
  assign wr_addr = AW'(item_i.entry_index);

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      table_mem[wr_addr] <= item_i.item_value;
    end
    rd_a_q <= table_mem[m_a];
    rd_b_q <= table_mem[m_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
    end else if (cfg_we_i) begin
      entries_q <= cfg_wdata_i;
    end
  end

  assign ge_a = rd_a_q >= key_q;
  assign eq_a = rd_a_q == key_q;
  assign gt_b = rd_b_q > key_q;
  assign eq_b = rd_b_q == key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_a_q <= '0;
      hx_a_q <= '0;
      lo_b_q <= '0;
      hx_b_q <= '0;
      lb_v_q <= 1'b0;
      ub_v_q <= 1'b0;
      fp_v_q <= 1'b0;
      lp_v_q <= 1'b0;
    end else if (cmd_i.start) begin
      lo_a_q <= '0;
      hx_a_q <= n_eff;
      lo_b_q <= '0;
      hx_b_q <= n_eff;
      lb_v_q <= 1'b0;
      ub_v_q <= 1'b0;
      fp_v_q <= 1'b0;
      lp_v_q <= 1'b0;
    end else if (cmd_i.update) begin
      if (act_a) begin
        if (ge_a) begin
          lb_v_q <= 1'b1;
          hx_a_q <= NW'(m_a);
        end else begin
          lo_a_q <= NW'(m_a) + NW'(1);
        end
        if (eq_a) begin
          fp_v_q <= 1'b1;
        end
      end
      if (act_b) begin
        if (gt_b) begin
          ub_v_q <= 1'b1;
          hx_b_q <= NW'(m_b);
        end else begin
          lo_b_q <= NW'(m_b) + NW'(1);
        end
        if (eq_b) begin
          lp_v_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q <= item_i.item_value;
    end
    if (cmd_i.update) begin
      if (act_a && ge_a) lb_q <= m_a;
      if (act_a && eq_a) fp_q <= m_a;
      if (act_b && gt_b) ub_q <= m_b;
      if (act_b && eq_b) lp_q <= m_b;
    end
  end

  assign found = fp_v_q && lp_v_q && (lp_q >= fp_q);
  assign span  = (AW+1)'(lp_q) - (AW+1)'(fp_q) + (AW+1)'(1);

  always_comb begin
    res_d                 = '0;
    res_d.lower_valid     = lb_v_q;
    res_d.upper_valid     = ub_v_q;
    res_d.found           = found;
    if (lb_v_q) res_d.lower_index = IdxW'(lb_q);
    if (ub_v_q) res_d.upper_index = IdxW'(ub_q);
    if (found) begin
      res_d.first_match_res = IdxW'(fp_q);
      res_d.last_match      = IdxW'(lp_q);
      res_d.match_count     = CntW'(span);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

>>> rtl/core/sorted_table_bound_search_unit.sv
`timescale 1ns / 1ps
// Channel | Direction | Payload           | Handshake
// in      | input     | stbs_pkg::item_t  | in_valid_i / in_stall_o
// out     | output    | stbs_pkg::result_t| out_valid_o / out_stall_i
// cfg     | input     | entries_in_use    | cfg_we_i (no wait, no read-back)
//
// Write transfer: stored when taken, stays idle. Query: start, then S =
// floor(log2 n) + 1 halving steps, a last read and finish; each step is one
// read of the dual-read table RAM and one compare/update, both searches in lock-step.
// Reset clears control and entries_in_use; table contents undefined until written.
// A finished result waits in the output register, so a new transfer is taken
// while out is stalled; a second result stays in the datapath until out is free.

module sorted_table_bound_search_unit #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  stbs_pkg::item_t           in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output stbs_pkg::result_t         out_data_o,
  input  logic                      cfg_we_i,
  input  logic [stbs_pkg::CntW-1:0] cfg_wdata_i
);
  import stbs_pkg::*;

  `include "assert_macros.svh"

  stbs_cmd_t    cmd;
  stbs_status_t status;

  // Sequencer: idle / read / compare / finish
  stbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .opcode_i    (in_data_i.opcode),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Table RAM, two search windows, result register.
  // Path A (>=) also yields first-equal and path B (>) last-equal, since the
  // equal-searches take the same branch decisions as their bound search.
  stbs_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (out_data_o)
  );

  // a result must never overwrite one still held by a stalled receiver
  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd.load_out && out_valid_o && out_stall_i, "result overwritten while stalled")
  // a query transfer must put the block into the busy state
  `ASSERT_PROP(a_busy_after_start, clk_i, rst_ni, cmd.start |=> in_stall_o, "not busy after query")
  // a search starts only on an accepted transfer
  `ASSERT_PROP(a_start_on_transfer, clk_i, rst_ni, cmd.start |-> (in_valid_i && !in_stall_o), "search started without transfer")
  // an equal entry also satisfies the lower bound
  `ASSERT_PROP(a_found_lower, clk_i, rst_ni, (out_valid_o && out_data_o.found) |-> out_data_o.lower_valid, "found without lower bound")

endmodule

>>> tb/sv/sorted_table_bound_search_unit_tb.sv
`timescale 1ns / 1ps

// Testbench for the sorted-table bound search unit.
//
// Stimulus flows through a backlog queue filled by the sequencing initial block.
// A clocked driver pops items from the backlog and offers them on the input
// channel. A clocked monitor drives the output stall and checks every result
// transfer against the oldest prediction.
//
// Predictions are made at the moment an input transfer is taken, from a local
// image of the table and of entries_in_use. Write transfers update the image.
// Query transfers run the four halving searches and queue the result they
// should produce.
//
// The table is fully written once, early in the run, so that no search ever
// touches an entry that has never been written.

module sorted_table_bound_search_unit_tb;

  import stbs_pkg::*;

  localparam int TblDepth     = 1024;
  localparam int ValMin       = 32'sh8000_0000;
  localparam int ValMax       = 32'sh7fff_ffff;
  localparam int ItemTarget   = 1100;     // every item sent, table loads included
  localparam int SettleCycles = 40;       // > one full query, covers a trailing write
  localparam int HoldCycles   = 500;      // long receiver hold-off
  localparam int CycleLimit   = 2000000;  // several times the slowest legal run

  // Search flavours: bound searches and first/last equal-position searches
  typedef enum int {
    FIND_LOWER,
    FIND_UPPER,
    FIND_FIRST,
    FIND_LAST
  } search_kind_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  item_t               in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  result_t             out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [CntW-1:0]     cfg_wdata_i = '0;

  // Stimulus and prediction state
  item_t               item_backlog[$];     // items waiting for the driver
  result_t             expected_bounds[$];  // predicted results, oldest first
  int                  model_tbl[TblDepth]; // table image, updated on transfer
  int                  plan_tbl[TblDepth];  // table image at queueing time, for keys
  logic [CntW-1:0]     model_count = '0;    // entries_in_use as seen by the block
  int                  err_count    = 0;
  int                  report_count = 0;
  int                  sent_items   = 0;
  int                  cycles       = 0;

  // Driver and monitor pacing
  int                  tx_gap_left   = 0;
  int                  tx_burst      = 0;
  int                  rx_stall_left = 0;
  int                  rx_burst      = 0;
  int                  hold_left     = 0;
  bit                  hold_req      = 1'b0;
  bit                  hold_done     = 1'b0;

  sorted_table_bound_search_unit #(
    .TABLE_DEPTH (TblDepth)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Classic halving loop over 0 .. n-1; gives a fixed answer even when unsorted
  function automatic int halving_search(int n, int key, search_kind_e kind);
    int lo;
    int hi;
    int mid;
    int hit;
    int v;
    lo  = 0;
    hi  = n - 1;
    hit = -1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      v   = model_tbl[mid];
      case (kind)
        FIND_LOWER: begin
          if (v >= key) begin
            hit = mid;
            hi  = mid - 1;
          end else lo = mid + 1;
        end
        FIND_UPPER: begin
          if (v > key) begin
            hit = mid;
            hi  = mid - 1;
          end else lo = mid + 1;
        end
        FIND_FIRST: begin
          if (v == key) begin
            hit = mid;
            hi  = mid - 1;
          end else if (v > key) hi = mid - 1;
          else lo = mid + 1;
        end
        default: begin
          if (v == key) begin
            hit = mid;
            lo  = mid + 1;
          end else if (v < key) lo = mid + 1;
          else hi = mid - 1;
        end
      endcase
    end
    return hit;
  endfunction

  function automatic result_t predict_bounds(int key);
    result_t r;
    int      n;
    int      lb;
    int      ub;
    int      fp;
    int      lp;
    int      span;
    // counts above the table depth saturate
    n  = (model_count > TblDepth) ? TblDepth : int'(model_count);
    lb = halving_search(n, key, FIND_LOWER);
    ub = halving_search(n, key, FIND_UPPER);
    fp = halving_search(n, key, FIND_FIRST);
    lp = halving_search(n, key, FIND_LAST);
    r  = '0;
    if (lb >= 0) begin
      r.lower_index = lb[IdxW-1:0];
      r.lower_valid = 1'b1;
    end
    if (ub >= 0) begin
      r.upper_index = ub[IdxW-1:0];
      r.upper_valid = 1'b1;
    end
    // a last position below the first one (unsorted table) counts as not found
    if (fp >= 0 && lp >= 0 && lp >= fp) begin
      span              = lp - fp + 1;
      r.first_match_res = fp[IdxW-1:0];
      r.last_match      = lp[IdxW-1:0];
      r.found           = 1'b1;
      r.match_count     = span[CntW-1:0];
    end
    return r;
  endfunction

  // Called once per accepted input transfer, in transfer order
  function automatic void record_item(item_t it);
    if (it.opcode == OP_WRITE) model_tbl[it.entry_index] = it.item_value;
    else expected_bounds.push_back(predict_bounds(it.item_value));
  endfunction

  function automatic string fmt_bounds(result_t r);
    return $sformatf("lo=%0d/%0b up=%0d/%0b first=%0d last=%0d found=%0b cnt=%0d",
                     r.lower_index, r.lower_valid, r.upper_index, r.upper_valid,
                     r.first_match_res, r.last_match, r.found, r.match_count);
  endfunction

  function automatic void check_result(result_t got);
    result_t want;
    bit      bad;
    if (expected_bounds.size() == 0) begin
      err_count++;
      if (report_count < 10) begin
        report_count++;
        $display("[%0t] result with nothing pending: %s", $realtime, fmt_bounds(got));
      end
      return;
    end
    want = expected_bounds.pop_front();
    bad  = (got.lower_index     !== want.lower_index)
        || (got.lower_valid     !== want.lower_valid)
        || (got.upper_index     !== want.upper_index)
        || (got.upper_valid     !== want.upper_valid)
        || (got.first_match_res !== want.first_match_res)
        || (got.last_match      !== want.last_match)
        || (got.found           !== want.found)
        || (got.match_count     !== want.match_count);
    if (bad) begin
      err_count++;
      if (report_count < 10) begin
        report_count++;
        $display("[%0t] mismatch\n  expected %s\n  actual   %s",
                 $realtime, fmt_bounds(want), fmt_bounds(got));
      end
    end
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one transfer in flight, payload held while stalled
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic valid_next;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      valid_next = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        record_item(in_data_i);
        valid_next = 1'b0;
      end
      if (!valid_next) begin
        if (tx_gap_left > 0) tx_gap_left--;
        else if (item_backlog.size() != 0) begin
          in_data_i  <= item_backlog.pop_front();
          valid_next = 1'b1;
          // gap chosen now, spent after this transfer
          if (tx_burst > 0) begin
            tx_burst--;
            tx_gap_left = 0;
          end else if ($urandom_range(0, 99) == 0) begin
            tx_burst    = $urandom_range(30, 150);
            tx_gap_left = 0;
          end else tx_gap_left = idle_len();
        end
      end
      in_valid_i <= valid_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks result transfers and paces the output stall
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic stall_next;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_result(out_data_o);
      // one long hold-off on request, so the block backs up and stalls its input
      if (hold_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
        if (rx_burst > 0) rx_burst--;
        else if ($urandom_range(0, 99) == 0) rx_burst = $urandom_range(50, 200);
        else rx_stall_left = idle_len();
      end
      out_stall_i <= stall_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  task automatic push_write(int idx, int val);
    item_t it;
    it.opcode      = OP_WRITE;
    it.entry_index = idx[IdxW-1:0];
    it.item_value  = val;
    plan_tbl[idx]  = val;
    item_backlog.push_back(it);
    sent_items++;
  endtask

  // entry_index is don't-care on a query; randomised so its bits still toggle
  task automatic push_query(int key);
    item_t it;
    it.opcode      = OP_QUERY;
    it.entry_index = IdxW'($urandom_range(0, TblDepth - 1));
    it.item_value  = key;
    item_backlog.push_back(it);
    sent_items++;
  endtask

  // Waits until the backlog is drained and every predicted result has come back,
  // then lets a trailing write finish. Sampled on the falling edge, away from
  // the driver's updates.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (item_backlog.size() != 0 || in_valid_i || expected_bounds.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // entries_in_use is only changed while the block is idle
  task automatic set_entries(int cnt);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cnt[CntW-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    model_count = cnt[CntW-1:0];
    @(negedge clk_i);
  endtask

  // Writes entries 0 .. m-1: nondecreasing with runs of duplicates, or scrambled
  task automatic load_table(int m, bit scrambled);
    longint cur;
    int     step_max;
    int     i;
    case ($urandom_range(0, 2))
      0:       cur = ValMin;
      1:       cur = longint'($signed($urandom));
      default: cur = longint'($urandom_range(0, 200)) - 100;
    endcase
    case ($urandom_range(0, 3))
      0:       step_max = 2;
      1:       step_max = 1000;
      2:       step_max = 1 << 20;
      default: step_max = ValMax;
    endcase
    for (i = 0; i < m; i++) begin
      if (scrambled) push_write(i, $urandom);
      else begin
        push_write(i, int'(cur));
        if ($urandom_range(0, 2) != 0) cur += $urandom_range(1, step_max);
        if (cur > ValMax) cur = ValMax;
      end
    end
  endtask

  // Keys: mostly table hits, then near misses, field extremes and noise
  function automatic int pick_key(int n);
    int r;
    int base;
    r    = $urandom_range(0, 99);
    base = (n > 0) ? plan_tbl[$urandom_range(0, n - 1)] : int'($urandom);
    if (r < 50) return base;
    if (r < 65) return ($urandom_range(0, 1) != 0) ? base + 1 : base - 1;
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0:       return ValMin;
        1:       return ValMax;
        2:       return 0;
        default: return -1;
      endcase
    end
    return int'($urandom);
  endfunction

  initial begin
    int cnt;
    int n_eff;
    int nq;
    int q;
    int sel;
    int phase;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty table after reset: every flag stays low
    push_query(ValMin);
    push_query(ValMax);

    // Full sorted load, duplicated minimum at the start and maximum at the end
    load_table(TblDepth, 1'b0);
    push_write(0, ValMin);
    push_write(1, ValMin);
    push_write(TblDepth - 2, ValMax);
    push_write(TblDepth - 1, ValMax);

    set_entries(TblDepth);
    push_query(ValMin);
    push_query(ValMax);
    push_query(plan_tbl[500]);
    push_query(plan_tbl[500] + 1);
    push_query(plan_tbl[500] - 1);
    push_query(0);
    push_query(-1);

    // Count beyond the table depth saturates
    set_entries(2047);
    push_query(plan_tbl[TblDepth - 1]);
    push_query(plan_tbl[0]);
    push_query($urandom);

    // Single entry
    set_entries(1);
    push_query(plan_tbl[0]);
    push_query(ValMax);

    // Broken ordering inside the searched range
    set_entries(8);
    push_write(2, ValMax);
    push_query(ValMax);
    push_query(plan_tbl[3]);

    set_entries(0);
    push_query(0);

    // Random phases: new count, small tables reloaded, then queries with some
    // stray writes that may break the ordering
    phase = 0;
    while (sent_items < ItemTarget || phase <= 3) begin
      sel = $urandom_range(0, 99);
      if (sel < 6) cnt = 0;
      else if (sel < 80) cnt = $urandom_range(1, 40);
      else if (sel < 92) cnt = $urandom_range(41, TblDepth - 1);
      else if (sel < 97) cnt = TblDepth;
      else cnt = $urandom_range(TblDepth + 1, 2047);
      nq = $urandom_range(4, 30);
      if (phase == 3) begin
        // back-pressure phase: long queue of queries against a held receiver
        cnt = TblDepth;
        nq  = 40;
      end
      n_eff = (cnt > TblDepth) ? TblDepth : cnt;
      set_entries(cnt);
      if (phase == 3) hold_req = 1'b1;
      if (phase != 3 && n_eff <= 64)
        load_table(n_eff, $urandom_range(0, 9) == 0);
      for (q = 0; q < nq; q++) begin
        if ($urandom_range(0, 11) == 0) push_write($urandom_range(0, TblDepth - 1), $urandom);
        else push_query(pick_key(n_eff));
      end
      phase++;
    end

    wait_idle();
    if (err_count == 0 && expected_bounds.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> sorted_table_bound_search_unit.f
+incdir+rtl/core
rtl/core/stbs_pkg.sv
rtl/core/stbs_ctrl.sv
rtl/core/stbs_dpath.sv
rtl/core/sorted_table_bound_search_unit.sv
tb/sv/sorted_table_bound_search_unit_tb.sv
